[rtl/core/sitoa_pkg.sv]
`default_nettype none

package sitoa_pkg;

    localparam int VALUE_W = 32;
    localparam int CHAR_W  = 6;
    localparam int DIGITS  = 10;
    localparam int BCD_W   = 4 * DIGITS;
    localparam int BITCNT_W = $clog2(VALUE_W);
    localparam int REM_W   = $clog2(DIGITS + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0] ASCII_MINUS = CHAR_W'(45);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SKIP,
        ST_SIGN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic skip;
        logic emit_sign;
        logic emit_digit;
    } cmd_t;

    typedef struct packed {
        logic conv_done;
        logic top_zero;
        logic more_digits;
        logic negative;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

[rtl/core/signed_int_to_decimal_ascii_core.sv]
`default_nettype none

// Renders a signed 32-bit integer as decimal ASCII, one character per output
// transfer: an optional '-' (45), then the digits '0'..'9' (48..57) with
// leading zeros dropped; zero gives a single '0'. last marks the final
// character of each number. The most negative value prints in full. An input
// transfer is accepted in the idle state, then the magnitude goes through
// bit-serial binary-to-BCD shifts, leading zeros are dropped to find the first
// digit, then one character per cycle follows when the output is not stalled.
// Dropped leading zeros and emitted digits always add up to the 10 BCD digits.
// The next input is taken only after the last character has been loaded into
// the single output register.
module signed_int_to_decimal_ascii_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic signed [sitoa_pkg::VALUE_W-1:0] value,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]            character,
    output logic                                    last
);
    import sitoa_pkg::*;

    cmd_t    cmd;
    status_t sts;

    sitoa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    sitoa_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .value     (value),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

endmodule

`default_nettype wire

[rtl/core/sitoa_ctrl.sv]
`default_nettype none

module sitoa_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire sitoa_pkg::status_t sts,
    output sitoa_pkg::cmd_t       cmd
);
    import sitoa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (sts.conv_done)
                begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (!(sts.top_zero && sts.more_digits))
                begin
                    state_next = sts.negative ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                if (sts.out_free)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free && !sts.more_digits)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            ST_CONVERT:
            begin
                cmd.shift = 1'b1;
            end
            ST_SKIP:
            begin
                cmd.skip = sts.top_zero && sts.more_digits;
            end
            ST_SIGN:
            begin
                cmd.emit_sign = sts.out_free;
            end
            ST_EMIT:
            begin
                cmd.emit_digit = sts.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/sitoa_dp.sv]
`default_nettype none

module sitoa_dp (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [sitoa_pkg::VALUE_W-1:0] value,
    input  wire sitoa_pkg::cmd_t                    cmd,
    output sitoa_pkg::status_t                      sts,
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [sitoa_pkg::CHAR_W-1:0]            character,
    output logic                                    last
);
    import sitoa_pkg::*;

    logic [VALUE_W-1:0]  mag_reg;
    logic [VALUE_W-1:0]  mag_next;
    logic [BCD_W-1:0]    bcd_reg;
    logic [BCD_W-1:0]    bcd_next;
    logic [BCD_W-1:0]    bcd_adj;
    logic [BITCNT_W-1:0] bitcnt_reg;
    logic [REM_W-1:0]    rem_reg;
    logic                neg_reg;
    logic                out_valid_reg;
    logic [CHAR_W-1:0]   char_reg;
    logic                last_reg;
    logic [3:0]          top_digit;

    assign top_digit = bcd_reg[BCD_W-1 -: 4];

    // add-3 correction ahead of each shift
    always_comb
    begin
        for (int i = 0; i < DIGITS; i++)
        begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ?
                                bcd_reg[4*i +: 4] + 4'd3 : bcd_reg[4*i +: 4];
        end
    end

    always_comb
    begin
        mag_next = mag_reg;
        bcd_next = bcd_reg;
        if (cmd.load)
        begin
            mag_next = value[VALUE_W-1] ? (~value + 1'b1) : value;
            bcd_next = '0;
        end
        else if (cmd.shift)
        begin
            mag_next = {mag_reg[VALUE_W-2:0], 1'b0};
            bcd_next = {bcd_adj[BCD_W-2:0], mag_reg[VALUE_W-1]};
        end
        else if (cmd.skip || cmd.emit_digit)
        begin
            bcd_next = {bcd_reg[BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bitcnt_reg    <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                bitcnt_reg <= '0;
                rem_reg    <= REM_W'(DIGITS);
            end
            else
            begin
                if (cmd.shift)
                begin
                    bitcnt_reg <= bitcnt_reg + 1'b1;
                end
                if (cmd.skip || cmd.emit_digit)
                begin
                    rem_reg <= rem_reg - 1'b1;
                end
            end
            if (cmd.emit_sign || cmd.emit_digit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        bcd_reg <= bcd_next;
        if (cmd.load)
        begin
            neg_reg <= value[VALUE_W-1];
        end
        if (cmd.emit_sign)
        begin
            char_reg <= ASCII_MINUS;
            last_reg <= 1'b0;
        end
        else if (cmd.emit_digit)
        begin
            char_reg <= ASCII_ZERO + CHAR_W'(top_digit);
            last_reg <= (rem_reg == REM_W'(1));
        end
    end

    assign sts.conv_done   = (bitcnt_reg == BITCNT_W'(VALUE_W - 1));
    assign sts.top_zero    = (top_digit == 4'd0);
    assign sts.more_digits = (rem_reg > REM_W'(1));
    assign sts.negative    = neg_reg;
    assign sts.out_free    = !out_valid_reg || !out_stall;

    assign out_valid = out_valid_reg;
    assign character = char_reg;
    assign last      = last_reg;

endmodule

`default_nettype wire

[test/tb.sv]
`timescale 1ns / 100ps

module tb;

    import sitoa_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              fin;
    } glyph_t;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic signed [VALUE_W-1:0] value;
    logic                      out_valid;
    logic                      out_stall;
    logic [CHAR_W-1:0]         character;
    logic                      last;

    glyph_t expected_glyphs[$];
    int     mismatches;
    int     idle_pct;
    int     stall_pct;

    signed_int_to_decimal_ascii_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .character (character),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("*** FAILED ***");
        $finish;
    end

    // decimal text of one value, pushed onto the expected queue
    task automatic predict_text(input logic signed [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] mag;
        logic [3:0]         digs[DIGITS];
        int                 n;
        glyph_t             g;
        begin
            mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
            n = 0;
            if (mag == 0)
            begin
                g.code = ASCII_ZERO;
                g.fin  = 1'b1;
                expected_glyphs.push_back(g);
            end
            else
            begin
                while (mag != 0)
                begin
                    digs[n] = 4'(mag % 10);
                    mag = mag / 10;
                    n++;
                end
                if (v[VALUE_W-1])
                begin
                    g.code = ASCII_MINUS;
                    g.fin  = 1'b0;
                    expected_glyphs.push_back(g);
                end
                for (int i = n - 1; i >= 0; i--)
                begin
                    g.code = ASCII_ZERO + CHAR_W'(digs[i]);
                    g.fin  = (i == 0);
                    expected_glyphs.push_back(g);
                end
            end
        end
    endtask

    // check every character transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_glyphs.size() == 0)
            begin
                $display("%0t: unexpected transfer character=%0d last=%0b",
                         $time, character, last);
                mismatches++;
            end
            else
            begin
                if (character !== expected_glyphs[0].code)
                begin
                    $display("%0t: character expected %0d actual %0d",
                             $time, expected_glyphs[0].code, character);
                    mismatches++;
                end
                if (last !== expected_glyphs[0].fin)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, expected_glyphs[0].fin, last);
                    mismatches++;
                end
                void'(expected_glyphs.pop_front());
            end
        end
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic send_value(input logic signed [VALUE_W-1:0] v);
        begin
            while ($urandom_range(99) < idle_pct)
            begin
                in_valid <= 1'b0;
                @(negedge clk);
            end
            in_valid <= 1'b1;
            value    <= v;
            do
                @(posedge clk);
            while (in_stall);
            predict_text(v);
            @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        int guard;
        begin
            guard = 0;
            in_valid <= 1'b0;
            while (expected_glyphs.size() != 0 && guard < 100000)
            begin
                @(negedge clk);
                guard++;
            end
            repeat (60) @(negedge clk);
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] random_value();
        longint lo;
        longint hi;
        longint m;
        int     ndig;
        int     pick;
        bit     neg;
        begin
            pick = $urandom_range(99);
            neg  = $urandom_range(1);
            if (pick < 15)
                return $urandom;
            if (pick < 22)
            begin
                case ($urandom_range(5))
                    0: return 0;
                    1: return 1;
                    2: return -1;
                    3: return 32'sh7fffffff;
                    4: return 32'sh80000000;
                    default: return 32'sh80000001;
                endcase
            end
            ndig = $urandom_range(1, DIGITS);
            lo = 1;
            for (int i = 1; i < ndig; i++)
                lo = lo * 10;
            if (ndig == DIGITS)
                hi = neg ? 64'd2147483648 : 64'd2147483647;
            else
                hi = lo * 10 - 1;
            m = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
            return neg ? VALUE_W'(-m) : VALUE_W'(m);
        end
    endfunction

    task automatic test_directed();
        logic signed [VALUE_W-1:0] vals[$];
        begin
            idle_pct  = 0;
            stall_pct = 0;
            vals = '{0, 1, -1, 7, -7, 9, 10, -10, 99, 100, -100,
                     999999999, 1000000000, -1000000000, 1234567890, -123456789,
                     32'sh7fffffff, 32'sh80000000, 32'sh80000001,
                     32'sh55555555, 32'shaaaaaaaa, 32'sh0000ffff, 32'shffff0000};
            foreach (vals[i])
            begin
                send_value(vals[i]);
                if (i == 10)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        begin
            idle_pct  = idle;
            stall_pct = stall;
            for (int i = 0; i < n; i++)
            begin
                send_value(random_value());
                if ($urandom_range(29) == 0)
                    wait_drained();
            end
            wait_drained();
        end
    endtask

    initial
    begin
        mismatches = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        value      = '0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_random(35, 0, 0);
        test_random(35, 54, 0);
        test_random(35, 0, 54);
        test_random(35, 21, 21);

        if (expected_glyphs.size() != 0)
        begin
            $display("%0t: %0d characters never arrived",
                     $time, expected_glyphs.size());
            mismatches++;
        end
        if (mismatches == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/sitoa_pkg.sv
rtl/core/sitoa_ctrl.sv
rtl/core/sitoa_dp.sv
rtl/core/signed_int_to_decimal_ascii_core.sv
test/tb.sv
